// ===== hdl/gtr_pkg.sv =====
// Package for the gravity tilt rotation block: widths, lane and step types.
// No dependencies; used by every module in hdl/.
package gtr_pkg;

  localparam int IN_W   = 16;              // input component width
  localparam int FRAC   = 14;              // fraction bits of Q1.FRAC outputs
  localparam int OUT_W  = FRAC + 2;        // output entry width
  localparam int SQ_W   = 2 * IN_W;        // width of a square or sum of squares
  localparam int SHIFT  = 2 * FRAC + 2;    // numerator scale for the root search
  localparam int R_W    = SQ_W + SHIFT;    // remainder width
  localparam int F_W    = FRAC + 2;        // root result, 2^(FRAC+1) scale
  localparam int B_W    = SQ_W + F_W;      // running root times denominator
  localparam int T_W    = SQ_W + 2 * FRAC + 4; // trial subtrahend width
  localparam int NSTEP  = F_W;             // one root bit per stage
  localparam int STEP_W = $clog2(NSTEP);
  localparam int NLANE  = 6;

  // root lanes
  localparam int L_CP  = 0;  // sqrt(yz/s)
  localparam int L_XS  = 1;  // |x|/|g|
  localparam int L_YYZ = 2;  // |y|/sqrt(yz)
  localparam int L_ZYZ = 3;  // |z|/sqrt(yz)
  localparam int L_YS  = 4;  // |y|/|g|
  localparam int L_ZS  = 5;  // |z|/|g|

  typedef struct packed {
    logic [R_W-1:0]  rem;
    logic [B_W-1:0]  bacc;
    logic [SQ_W-1:0] den;
    logic [F_W-1:0]  f;
  } lane_t;

  typedef lane_t [NLANE-1:0] lanes_t;

  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic z_neg;
    logic zero;
    logic yz_zero;
  } meta_t;

endpackage

// ===== hdl/gravity_tilt_rotation_top.sv =====
// Top level of the gravity tilt rotation block: prep, root stages, finish.
// Depends on gtr_pkg, gtr_prep, gtr_root_step, gtr_finish.
//
//  channel | signals                      | fields
//  input   | in_valid, in_stall           | grav_x, grav_y, grav_z
//  output  | out_valid, out_stall         | r00..r22, zero_vector
//
// Pipeline: two prep stages, one stage per root bit, two finish stages.
// One transaction per cycle while the output is not stalled.
// Reset clears only the valid bits. The whole pipeline holds while the
// output register is full and stalled; in_stall reflects that hold.
module gravity_tilt_rotation_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [gtr_pkg::IN_W-1:0]  grav_x,
  input  logic signed [gtr_pkg::IN_W-1:0]  grav_y,
  input  logic signed [gtr_pkg::IN_W-1:0]  grav_z,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [gtr_pkg::OUT_W-1:0] r00,
  output logic signed [gtr_pkg::OUT_W-1:0] r01,
  output logic signed [gtr_pkg::OUT_W-1:0] r02,
  output logic signed [gtr_pkg::OUT_W-1:0] r10,
  output logic signed [gtr_pkg::OUT_W-1:0] r11,
  output logic signed [gtr_pkg::OUT_W-1:0] r12,
  output logic signed [gtr_pkg::OUT_W-1:0] r20,
  output logic signed [gtr_pkg::OUT_W-1:0] r21,
  output logic signed [gtr_pkg::OUT_W-1:0] r22,
  output logic                             zero_vector
);

  logic en;
  logic            v   [gtr_pkg::NSTEP+1];
  gtr_pkg::meta_t  md  [gtr_pkg::NSTEP+1];
  gtr_pkg::lanes_t ln  [gtr_pkg::NSTEP+1];

  // global advance: hold only when a finished result is waiting
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  gtr_prep u_prep (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .grav_x(grav_x), .grav_y(grav_y), .grav_z(grav_z),
    .valid(v[0]), .meta(md[0]), .lanes(ln[0])
  );

  // root search, most significant bit first
  for (genvar i = 0; i < gtr_pkg::NSTEP; i++) begin : g_step
    gtr_root_step u_step (
      .clk(clk), .rst(rst), .en(en),
      .bit_idx(gtr_pkg::STEP_W'(gtr_pkg::NSTEP - 1 - i)),
      .valid_in(v[i]), .meta_in(md[i]), .lanes_in(ln[i]),
      .valid(v[i+1]), .meta(md[i+1]), .lanes(ln[i+1])
    );
  end

  gtr_finish u_finish (
    .clk(clk), .rst(rst), .en(en),
    .valid_in(v[gtr_pkg::NSTEP]), .meta_in(md[gtr_pkg::NSTEP]),
    .lanes_in(ln[gtr_pkg::NSTEP]),
    .valid(out_valid),
    .r00(r00), .r01(r01), .r02(r02),
    .r10(r10), .r11(r11), .r12(r12),
    .r20(r20), .r21(r21), .r22(r22),
    .zero_vector(zero_vector)
  );

endmodule

// ===== hdl/gtr_prep.sv =====
// Front end: absolute values, squares, sums of squares, root lane setup.
// Depends on gtr_pkg. Two register stages.
module gtr_prep (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic signed [gtr_pkg::IN_W-1:0] grav_x,
  input  logic signed [gtr_pkg::IN_W-1:0] grav_y,
  input  logic signed [gtr_pkg::IN_W-1:0] grav_z,
  output logic                       valid,
  output gtr_pkg::meta_t             meta,
  output gtr_pkg::lanes_t            lanes
);

  logic [gtr_pkg::IN_W-1:0] ax, ay, az;
  logic                     v1;
  logic [gtr_pkg::SQ_W-1:0] sqx, sqy, sqz;
  logic                     xn, yn, zn;
  logic [gtr_pkg::SQ_W-1:0] yz, s;
  gtr_pkg::lanes_t          lanes_next;
  gtr_pkg::meta_t           meta_next;

  // magnitudes; the most negative value maps to 2^(IN_W-1) unsigned
  assign ax = grav_x[gtr_pkg::IN_W-1] ? gtr_pkg::IN_W'(-grav_x) : gtr_pkg::IN_W'(grav_x);
  assign ay = grav_y[gtr_pkg::IN_W-1] ? gtr_pkg::IN_W'(-grav_y) : gtr_pkg::IN_W'(grav_y);
  assign az = grav_z[gtr_pkg::IN_W-1] ? gtr_pkg::IN_W'(-grav_z) : gtr_pkg::IN_W'(grav_z);

  // stage 1: squares
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      sqx <= gtr_pkg::SQ_W'(ax) * gtr_pkg::SQ_W'(ax);
      sqy <= gtr_pkg::SQ_W'(ay) * gtr_pkg::SQ_W'(ay);
      sqz <= gtr_pkg::SQ_W'(az) * gtr_pkg::SQ_W'(az);
      xn  <= grav_x[gtr_pkg::IN_W-1];
      yn  <= grav_y[gtr_pkg::IN_W-1];
      zn  <= grav_z[gtr_pkg::IN_W-1];
    end
  end

  // sums and lane setup
  assign yz = sqy + sqz;
  assign s  = yz + sqx;

  function automatic gtr_pkg::lane_t lane_init(input logic [gtr_pkg::SQ_W-1:0] num,
                                               input logic [gtr_pkg::SQ_W-1:0] den);
    gtr_pkg::lane_t l;
    l.rem  = {num, {gtr_pkg::SHIFT{1'b0}}};
    l.bacc = '0;
    l.den  = den;
    l.f    = '0;
    return l;
  endfunction

  always_comb begin
    lanes_next[gtr_pkg::L_CP]  = lane_init(yz, s);
    lanes_next[gtr_pkg::L_XS]  = lane_init(sqx, s);
    lanes_next[gtr_pkg::L_YYZ] = lane_init(sqy, yz);
    lanes_next[gtr_pkg::L_ZYZ] = lane_init(sqz, yz);
    lanes_next[gtr_pkg::L_YS]  = lane_init(sqy, s);
    lanes_next[gtr_pkg::L_ZS]  = lane_init(sqz, s);
    meta_next.x_neg   = xn;
    meta_next.y_neg   = yn;
    meta_next.z_neg   = zn;
    meta_next.zero    = (s == '0);
    meta_next.yz_zero = (yz == '0);
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= v1;
    end
    if (en) begin
      lanes <= lanes_next;
      meta  <= meta_next;
    end
  end

endmodule

// ===== hdl/gtr_root_step.sv =====
// One stage of the six-lane ratio square root: decides one result bit.
// Depends on gtr_pkg. Finds largest f with f^2*den <= num*2^SHIFT.
module gtr_root_step (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic [gtr_pkg::STEP_W-1:0]  bit_idx,
  input  logic                        valid_in,
  input  gtr_pkg::meta_t              meta_in,
  input  gtr_pkg::lanes_t             lanes_in,
  output logic                        valid,
  output gtr_pkg::meta_t              meta,
  output gtr_pkg::lanes_t             lanes
);

  gtr_pkg::lanes_t lanes_next;

  // trial: (q+2^b)^2 den - q^2 den = 2^(b+1) q den + 2^(2b) den
  always_comb begin
    logic [gtr_pkg::T_W-1:0] t;
    logic [gtr_pkg::T_W-1:0] r;
    for (int i = 0; i < gtr_pkg::NLANE; i++) begin
      t = (gtr_pkg::T_W'(lanes_in[i].bacc)
            << ({1'b0, bit_idx} + (gtr_pkg::STEP_W + 1)'(1)))
        + (gtr_pkg::T_W'(lanes_in[i].den) << {bit_idx, 1'b0});
      r = gtr_pkg::T_W'(lanes_in[i].rem);
      lanes_next[i] = lanes_in[i];
      if (r >= t) begin
        lanes_next[i].rem  = lanes_in[i].rem - t[gtr_pkg::R_W-1:0];
        lanes_next[i].bacc = lanes_in[i].bacc
                           + (gtr_pkg::B_W'(lanes_in[i].den) << bit_idx);
        lanes_next[i].f    = lanes_in[i].f | (gtr_pkg::F_W'(1) << bit_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
    if (en) begin
      lanes <= lanes_next;
      meta  <= meta_in;
    end
  end

endmodule

// ===== hdl/gtr_finish.sv =====
// Back end: rounding, signs, special cases, the two products, output register.
// Depends on gtr_pkg. Two register stages.
module gtr_finish (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             valid_in,
  input  gtr_pkg::meta_t                   meta_in,
  input  gtr_pkg::lanes_t                  lanes_in,
  output logic                             valid,
  output logic signed [gtr_pkg::OUT_W-1:0] r00,
  output logic signed [gtr_pkg::OUT_W-1:0] r01,
  output logic signed [gtr_pkg::OUT_W-1:0] r02,
  output logic signed [gtr_pkg::OUT_W-1:0] r10,
  output logic signed [gtr_pkg::OUT_W-1:0] r11,
  output logic signed [gtr_pkg::OUT_W-1:0] r12,
  output logic signed [gtr_pkg::OUT_W-1:0] r20,
  output logic signed [gtr_pkg::OUT_W-1:0] r21,
  output logic signed [gtr_pkg::OUT_W-1:0] r22,
  output logic                             zero_vector
);

  localparam logic signed [gtr_pkg::OUT_W-1:0] ONE = gtr_pkg::OUT_W'(1) << gtr_pkg::FRAC;
  localparam logic [2*gtr_pkg::OUT_W-1:0] HALF =
    (2*gtr_pkg::OUT_W)'(1) << (gtr_pkg::FRAC - 1);

  logic [gtr_pkg::OUT_W-1:0] q [gtr_pkg::NLANE];
  logic signed [gtr_pkg::OUT_W-1:0] cp, sp, sr, cr, ys, zs;

  logic                              v1;
  gtr_pkg::meta_t                    m1;
  logic signed [gtr_pkg::OUT_W-1:0]  cp1, sp1, sr1, cr1, ys1, zs1;
  logic signed [2*gtr_pkg::OUT_W-1:0] p10, p20;

  // round to nearest: q = (f + 1) >> 1
  always_comb begin
    logic [gtr_pkg::F_W:0] sum;
    for (int i = 0; i < gtr_pkg::NLANE; i++) begin
      sum  = {1'b0, lanes_in[i].f} + 1'b1;
      q[i] = gtr_pkg::OUT_W'(sum[gtr_pkg::F_W:1]);
    end
  end

  // signed ratios, roll forced to zero when y and z are both zero
  always_comb begin
    cp = q[gtr_pkg::L_CP];
    sp = meta_in.x_neg ? q[gtr_pkg::L_XS] : -q[gtr_pkg::L_XS];
    sr = meta_in.y_neg ? -q[gtr_pkg::L_YYZ] : q[gtr_pkg::L_YYZ];
    cr = meta_in.z_neg ? -q[gtr_pkg::L_ZYZ] : q[gtr_pkg::L_ZYZ];
    ys = meta_in.y_neg ? -q[gtr_pkg::L_YS] : q[gtr_pkg::L_YS];
    zs = meta_in.z_neg ? -q[gtr_pkg::L_ZS] : q[gtr_pkg::L_ZS];
    if (meta_in.yz_zero) begin
      sr = '0;
      cr = ONE;
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= valid_in;
    end
    if (en) begin
      m1  <= meta_in;
      cp1 <= cp;
      sp1 <= sp;
      sr1 <= sr;
      cr1 <= cr;
      ys1 <= ys;
      zs1 <= zs;
      p10 <= (2*gtr_pkg::OUT_W)'(sp) * (2*gtr_pkg::OUT_W)'(sr);
      p20 <= (2*gtr_pkg::OUT_W)'(sp) * (2*gtr_pkg::OUT_W)'(cr);
    end
  end

  // product rounding, magnitude based so ties go away from zero
  function automatic logic signed [gtr_pkg::OUT_W-1:0] qround(
    input logic signed [2*gtr_pkg::OUT_W-1:0] p);
    logic [2*gtr_pkg::OUT_W-1:0] mag;
    logic [2*gtr_pkg::OUT_W-1:0] rnd;
    mag = p[2*gtr_pkg::OUT_W-1] ? (2*gtr_pkg::OUT_W)'(-p) : (2*gtr_pkg::OUT_W)'(p);
    rnd = (mag + HALF) >> gtr_pkg::FRAC;
    return p[2*gtr_pkg::OUT_W-1] ? -gtr_pkg::OUT_W'(rnd) : gtr_pkg::OUT_W'(rnd);
  endfunction

  // stage 2: output register, identity on a zero vector
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= v1;
    end
    if (en) begin
      zero_vector <= m1.zero;
      r01 <= '0;
      if (m1.zero) begin
        r00 <= ONE; r02 <= '0;
        r10 <= '0;  r11 <= ONE; r12 <= '0;
        r20 <= '0;  r21 <= '0;  r22 <= ONE;
      end else begin
        r00 <= cp1;          r02 <= -sp1;
        r10 <= qround(p10);  r11 <= cr1;  r12 <= ys1;
        r20 <= qround(p20);  r21 <= -sr1; r22 <= zs1;
      end
    end
  end

endmodule
